FILE: rtl/tnia_pkg.sv
// Package with the types, constants and codes shared by the tree node insert unit.
`default_nettype none

package tnia_pkg;

  // Field widths of the node transactions.
  localparam int unsigned POS_W     = 24;
  localparam int unsigned DIR_W     = 16;
  localparam int unsigned IDX_W     = 10;
  localparam int unsigned UNIT_W    = 16;
  localparam int unsigned LEN_W     = 32;
  localparam int unsigned FLAG_W    = 8;
  localparam int unsigned STS_W     = 2;
  localparam int unsigned CFG_W     = 32;
  localparam int unsigned CFG_IDX_W = 1;

  // Default table depth.
  localparam int unsigned MAX_NODES_DEF = 1024;

  // Saturation limit of depth and child count, and the unit length in Q1.14.
  localparam int unsigned SAT10    = 1023;
  localparam int unsigned UNIT_ONE = 16384;

  // Datapath widths.
  localparam int unsigned DIFF_W     = POS_W + 1;
  localparam int unsigned ABS_W      = DIR_W + 1;
  localparam int unsigned MUL_W      = DIFF_W;
  localparam int unsigned PROD_W     = 2 * MUL_W;
  localparam int unsigned ACC_W      = PROD_W + 2;
  localparam int unsigned ROOT_STEPS = 32;
  localparam int unsigned RAD_W      = 2 * ROOT_STEPS;
  localparam int unsigned REM_W      = ROOT_STEPS + 4;
  localparam int unsigned STEP_W     = $clog2(ROOT_STEPS);
  localparam int unsigned NORM_SHIFT = 28;
  localparam int unsigned S2_W       = 34;
  localparam int unsigned QUOT_W     = 15;
  localparam int unsigned NUM_W      = ROOT_STEPS + QUOT_W - 1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_DIR_ZERO_LIMIT  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROOT_FLAG_VALUE = 1'b1;

  // Result status codes.
  typedef enum logic [STS_W-1:0] {
    STS_OK         = 2'd0,
    STS_BAD_PARENT = 2'd1,
    STS_FULL       = 2'd2
  } status_e;

  // Input transaction.
  typedef struct packed {
    logic                    op;
    logic [IDX_W-1:0]        parent_index;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] pos_z;
    logic signed [DIR_W-1:0] dir_x;
    logic signed [DIR_W-1:0] dir_y;
    logic signed [DIR_W-1:0] dir_z;
    logic [FLAG_W-1:0]       flags;
  } in_t;

  // Result transaction.
  typedef struct packed {
    logic [STS_W-1:0]         status;
    logic [IDX_W-1:0]         node_index;
    logic [IDX_W-1:0]         depth;
    logic [LEN_W-1:0]         along_len;
    logic signed [UNIT_W-1:0] unit_x;
    logic signed [UNIT_W-1:0] unit_y;
    logic signed [UNIT_W-1:0] unit_z;
    logic [IDX_W-1:0]         parent_children;
    logic [FLAG_W-1:0]        node_flags;
  } out_t;

  // One stored node.
  typedef struct packed {
    logic signed [POS_W-1:0]  pos_x;
    logic signed [POS_W-1:0]  pos_y;
    logic signed [POS_W-1:0]  pos_z;
    logic signed [UNIT_W-1:0] unit_x;
    logic signed [UNIT_W-1:0] unit_y;
    logic signed [UNIT_W-1:0] unit_z;
    logic [IDX_W-1:0]         depth;
    logic [LEN_W-1:0]         along;
  } node_rec_t;

  // Datapath operations issued by the controller.
  typedef enum logic [3:0] {
    DP_NOP,
    DP_LOAD,
    DP_LOOKUP,
    DP_SQ,
    DP_DROOT_LD,
    DP_ROOT_STEP,
    DP_ALONG,
    DP_NCHK,
    DP_NROOT_LD,
    DP_DIV_LD,
    DP_DIV_STEP,
    DP_DIV_END,
    DP_WR_NODE,
    DP_WR_PAR,
    DP_OUT
  } dp_op_e;

  // Controller states.
  typedef enum logic [4:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_DSQ,
    ST_DROOT_LD,
    ST_DROOT,
    ST_ALONG,
    ST_NSQ,
    ST_NCHK,
    ST_NSQ2,
    ST_NROOT_LD,
    ST_NROOT,
    ST_DIV_LD,
    ST_DIV,
    ST_DIV_END,
    ST_WR_NODE,
    ST_WR_PAR,
    ST_DONE
  } ctrl_state_e;

  // Command from controller to datapath.
  typedef struct packed {
    dp_op_e     op;
    logic [1:0] axis;
    logic       sq_dir;
  } dp_cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    status_e err;
    logic    is_root;
    logic    fallback;
  } dp_sts_t;

endpackage

`default_nettype wire

FILE: rtl/tnia_ram.sv
// Generic single-port-write, registered-read RAM.
`default_nettype none

module tnia_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]              rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: rtl/tnia_datapath.sv
// Datapath: node store, shared multiplier, square root and divider iterations.
`default_nettype none

module tnia_datapath import tnia_pkg::*; #(
  parameter int unsigned MAX_NODES = MAX_NODES_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire dp_cmd_t               cmd_i,
  output dp_sts_t                    sts_o,
  input  wire in_t                   in_data_i,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_W-1:0]      cfg_wdata_i,
  output out_t                       out_data_o
);

  localparam int unsigned AW = $clog2(MAX_NODES);
  localparam int unsigned CW = $clog2(MAX_NODES + 1);
  localparam int unsigned REC_W = $bits(node_rec_t);

  // Control state.
  logic [CW-1:0]     count_q, count_d;
  logic [CFG_W-1:0]  limit_q;
  logic [FLAG_W-1:0] root_flag_q;

  // Payload registers.
  in_t                      in_q;
  logic [ABS_W-1:0]         a_q [3];
  logic [ACC_W-1:0]         acc_q;
  logic [RAD_W-1:0]         x_q;
  logic [REM_W-1:0]         rem_q;
  logic [ROOT_STEPS-1:0]    root_q;
  logic [NUM_W-1:0]         r_q;
  logic [NUM_W-1:0]         dv_q;
  logic [QUOT_W-1:0]        q_q;
  logic signed [UNIT_W-1:0] unit_q [3];
  logic [IDX_W-1:0]         depth_q;
  logic [LEN_W-1:0]         along_q;
  logic [IDX_W-1:0]         pc_q;
  out_t                     out_q;

  // Store ports.
  logic             rec_we, cnt_we, rd_re;
  logic [AW-1:0]    par_addr, idx_addr, cnt_waddr;
  logic [IDX_W-1:0] cnt_wdata, cnt_rdata;
  logic [REC_W-1:0] rec_rdata;
  node_rec_t        rd_rec, wr_rec;

  // Derived values.
  logic signed [POS_W-1:0] cur_pos [3];
  logic signed [POS_W-1:0] par_pos [3];
  logic signed [DIR_W-1:0] dir_v [3];
  logic [ABS_W-1:0]        dir_abs [3];
  logic signed [DIFF_W-1:0] diff;
  logic [MUL_W-1:0]        mul_a;
  logic [PROD_W-1:0]       prod;
  logic [REM_W-1:0]        rem_n, trial;
  logic                    bump;
  logic [LEN_W+1:0]        along_sum;
  logic [ABS_W-1:0]        mx;
  logic [3:0]              lz;
  logic [QUOT_W-1:0]       q_clamp;
  logic signed [UNIT_W-1:0] q_signed;
  status_e                 err;
  logic                    fallback;
  out_t                    out_d;

  // A root always lands in entry 0, a child in the next free entry.
  assign par_addr = AW'(in_q.parent_index);
  assign idx_addr = in_q.op ? '0 : count_q[AW-1:0];
  assign rd_rec   = node_rec_t'(rec_rdata);

  assign cur_pos[0] = in_q.pos_x;
  assign cur_pos[1] = in_q.pos_y;
  assign cur_pos[2] = in_q.pos_z;
  assign par_pos[0] = rd_rec.pos_x;
  assign par_pos[1] = rd_rec.pos_y;
  assign par_pos[2] = rd_rec.pos_z;
  assign dir_v[0]   = in_q.dir_x;
  assign dir_v[1]   = in_q.dir_y;
  assign dir_v[2]   = in_q.dir_z;

  // Absolute raw direction components.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dir_abs[i] = dir_v[i][DIR_W-1] ? ABS_W'(-{dir_v[i][DIR_W-1], dir_v[i]})
                                     : ABS_W'({dir_v[i][DIR_W-1], dir_v[i]});
    end
  end

  // Parent checks: existence first, then table space.
  always_comb begin
    if (in_q.op) begin
      err = STS_OK;
    end else if ({{CW{1'b0}}, in_q.parent_index} >= {{IDX_W{1'b0}}, count_q}) begin
      err = STS_BAD_PARENT;
    end else if (count_q == CW'(MAX_NODES)) begin
      err = STS_FULL;
    end else begin
      err = STS_OK;
    end
  end

  assign fallback = (acc_q == '0) || (acc_q < ACC_W'(limit_q));

  assign sts_o.err      = err;
  assign sts_o.is_root  = in_q.op;
  assign sts_o.fallback = fallback;

  // Shared squarer: position difference or direction magnitude.
  always_comb begin
    diff  = DIFF_W'(cur_pos[cmd_i.axis]) - DIFF_W'(par_pos[cmd_i.axis]);
    mul_a = cmd_i.sq_dir ? MUL_W'(a_q[cmd_i.axis])
                         : (diff[DIFF_W-1] ? MUL_W'(-diff) : MUL_W'(diff));
    prod  = PROD_W'(mul_a) * PROD_W'(mul_a);
  end

  // One bit of the square root per step.
  assign rem_n = {rem_q[REM_W-3:0], x_q[RAD_W-1 -: 2]};
  assign trial = {2'b00, root_q, 2'b01};

  // Rounded distance added to the parent's arc length.
  assign bump      = rem_q > REM_W'(root_q);
  assign along_sum = (LEN_W+2)'(rd_rec.along) + (LEN_W+2)'(root_q) + (LEN_W+2)'(bump);

  // Leading zeros of the largest magnitude below its top bit.
  always_comb begin
    mx = a_q[0];
    if (a_q[1] > mx) mx = a_q[1];
    if (a_q[2] > mx) mx = a_q[2];
    lz = 4'd0;
    for (int i = 0; i < 16; i++) begin
      if (mx[i]) lz = 4'(15 - i);
    end
  end

  // Clamped and signed quotient.
  assign q_clamp  = (q_q > QUOT_W'(UNIT_ONE)) ? QUOT_W'(UNIT_ONE) : q_q;
  assign q_signed = dir_v[cmd_i.axis][DIR_W-1] ? UNIT_W'(0) - UNIT_W'(q_clamp)
                                               : UNIT_W'(q_clamp);

  // Result transaction; every field but the status is zero on an error.
  always_comb begin
    out_d        = '0;
    out_d.status = err;
    if (err == STS_OK) begin
      out_d.node_index      = in_q.op ? '0 : IDX_W'(count_q);
      out_d.depth           = depth_q;
      out_d.along_len       = along_q;
      out_d.unit_x          = unit_q[0];
      out_d.unit_y          = unit_q[1];
      out_d.unit_z          = unit_q[2];
      out_d.parent_children = pc_q;
      out_d.node_flags      = in_q.op ? root_flag_q : in_q.flags;
    end
  end

  // Node store writes and reads.
  always_comb begin
    rec_we    = cmd_i.op == DP_WR_NODE;
    cnt_we    = (cmd_i.op == DP_WR_NODE) || (cmd_i.op == DP_WR_PAR);
    cnt_waddr = (cmd_i.op == DP_WR_PAR) ? par_addr : idx_addr;
    cnt_wdata = (cmd_i.op == DP_WR_PAR) ? pc_q : '0;
    rd_re     = cmd_i.op == DP_LOOKUP;
    wr_rec.pos_x  = in_q.pos_x;
    wr_rec.pos_y  = in_q.pos_y;
    wr_rec.pos_z  = in_q.pos_z;
    wr_rec.unit_x = unit_q[0];
    wr_rec.unit_y = unit_q[1];
    wr_rec.unit_z = unit_q[2];
    wr_rec.depth  = depth_q;
    wr_rec.along  = along_q;
  end

  tnia_ram #(.WIDTH(REC_W), .DEPTH(MAX_NODES)) u_rec_ram (
    .clk_i   (clk_i),
    .we_i    (rec_we),
    .waddr_i (idx_addr),
    .wdata_i (wr_rec),
    .re_i    (rd_re),
    .raddr_i (par_addr),
    .rdata_o (rec_rdata)
  );

  tnia_ram #(.WIDTH(IDX_W), .DEPTH(MAX_NODES)) u_cnt_ram (
    .clk_i   (clk_i),
    .we_i    (cnt_we),
    .waddr_i (cnt_waddr),
    .wdata_i (cnt_wdata),
    .re_i    (rd_re),
    .raddr_i (par_addr),
    .rdata_o (cnt_rdata)
  );

  // Node count follows each delivered successful transaction.
  always_comb begin
    count_d = count_q;
    if ((cmd_i.op == DP_OUT) && (err == STS_OK)) begin
      count_d = in_q.op ? CW'(1) : count_q + CW'(1);
    end
  end

  // Control state and configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      limit_q     <= CFG_W'(1);
      root_flag_q <= FLAG_W'(1);
    end else begin
      count_q <= count_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_DIR_ZERO_LIMIT:  limit_q     <= cfg_wdata_i;
          CFG_ROOT_FLAG_VALUE: root_flag_q <= cfg_wdata_i[FLAG_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // Payload registers, one operation per cycle.
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      DP_LOAD: begin
        in_q <= in_data_i;
      end
      DP_LOOKUP: begin
        for (int i = 0; i < 3; i++) a_q[i] <= dir_abs[i];
        along_q <= '0;
        depth_q <= '0;
        pc_q    <= '0;
      end
      DP_SQ: begin
        acc_q <= (cmd_i.axis == 2'd0) ? ACC_W'(prod) : acc_q + ACC_W'(prod);
      end
      DP_DROOT_LD: begin
        x_q    <= RAD_W'(acc_q);
        rem_q  <= '0;
        root_q <= '0;
      end
      DP_NROOT_LD: begin
        x_q    <= {2'b00, acc_q[S2_W-1:0], {NORM_SHIFT{1'b0}}};
        rem_q  <= '0;
        root_q <= '0;
      end
      DP_ROOT_STEP: begin
        x_q <= {x_q[RAD_W-3:0], 2'b00};
        if (rem_n >= trial) begin
          rem_q  <= rem_n - trial;
          root_q <= {root_q[ROOT_STEPS-2:0], 1'b1};
        end else begin
          rem_q  <= rem_n;
          root_q <= {root_q[ROOT_STEPS-2:0], 1'b0};
        end
      end
      DP_ALONG: begin
        along_q <= (along_sum[LEN_W+1:LEN_W] != 2'b00) ? '1 : along_sum[LEN_W-1:0];
        depth_q <= (rd_rec.depth < IDX_W'(SAT10)) ? rd_rec.depth + IDX_W'(1)
                                                 : IDX_W'(SAT10);
        pc_q    <= (cnt_rdata < IDX_W'(SAT10)) ? cnt_rdata + IDX_W'(1) : IDX_W'(SAT10);
      end
      DP_NCHK: begin
        if (fallback) begin
          if (in_q.op) begin
            unit_q[0] <= '0;
            unit_q[1] <= '0;
            unit_q[2] <= UNIT_W'(UNIT_ONE);
          end else begin
            unit_q[0] <= rd_rec.unit_x;
            unit_q[1] <= rd_rec.unit_y;
            unit_q[2] <= rd_rec.unit_z;
          end
        end else begin
          // Bring the largest magnitude into the top octave of 16 bits.
          for (int i = 0; i < 3; i++) begin
            a_q[i] <= mx[ABS_W-1] ? (a_q[i] >> 1) : (a_q[i] << lz);
          end
        end
      end
      DP_DIV_LD: begin
        r_q  <= NUM_W'({a_q[cmd_i.axis], {NORM_SHIFT{1'b0}}}) + NUM_W'(root_q >> 1);
        dv_q <= {root_q, {(QUOT_W-1){1'b0}}};
        q_q  <= '0;
      end
      DP_DIV_STEP: begin
        dv_q <= dv_q >> 1;
        if (r_q >= dv_q) begin
          r_q <= r_q - dv_q;
          q_q <= {q_q[QUOT_W-2:0], 1'b1};
        end else begin
          q_q <= {q_q[QUOT_W-2:0], 1'b0};
        end
      end
      DP_DIV_END: begin
        unit_q[cmd_i.axis] <= q_signed;
      end
      DP_OUT: begin
        out_q <= out_d;
      end
      default: ;
    endcase
  end

  assign out_data_o = out_q;

endmodule

`default_nettype wire

FILE: rtl/tnia_ctrl.sv
// Controller state machine sequencing the insert datapath.
`default_nettype none

module tnia_ctrl import tnia_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output logic         in_stall_o,
  output logic         out_valid_o,
  input  wire logic    out_stall_i,
  input  wire dp_sts_t sts_i,
  output dp_cmd_t      cmd_o
);

  ctrl_state_e       state_q, state_d;
  logic [1:0]        axis_q, axis_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic              out_valid_q, out_valid_d;

  // State, counters and output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      axis_q      <= '0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      axis_q      <= axis_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Next state and datapath commands.
  always_comb begin
    state_d     = state_q;
    axis_d      = axis_q;
    step_d      = step_q;
    out_valid_d = out_valid_q && out_stall_i;
    cmd_o.op     = DP_NOP;
    cmd_o.axis   = axis_q;
    cmd_o.sq_dir = 1'b1;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = DP_LOAD;
          state_d  = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        cmd_o.op = DP_LOOKUP;
        axis_d   = '0;
        if (sts_i.err != STS_OK) begin
          state_d = ST_DONE;
        end else if (sts_i.is_root) begin
          state_d = ST_NSQ;
        end else begin
          state_d = ST_DSQ;
        end
      end
      ST_DSQ: begin
        cmd_o.op     = DP_SQ;
        cmd_o.sq_dir = 1'b0;
        if (axis_q == 2'd2) begin
          axis_d  = '0;
          state_d = ST_DROOT_LD;
        end else begin
          axis_d = axis_q + 2'd1;
        end
      end
      ST_DROOT_LD: begin
        cmd_o.op = DP_DROOT_LD;
        step_d   = '0;
        state_d  = ST_DROOT;
      end
      ST_DROOT: begin
        cmd_o.op = DP_ROOT_STEP;
        step_d   = step_q + STEP_W'(1);
        if (step_q == STEP_W'(ROOT_STEPS - 1)) begin
          state_d = ST_ALONG;
        end
      end
      ST_ALONG: begin
        cmd_o.op = DP_ALONG;
        axis_d   = '0;
        state_d  = ST_NSQ;
      end
      ST_NSQ: begin
        cmd_o.op = DP_SQ;
        if (axis_q == 2'd2) begin
          axis_d  = '0;
          state_d = ST_NCHK;
        end else begin
          axis_d = axis_q + 2'd1;
        end
      end
      ST_NCHK: begin
        cmd_o.op = DP_NCHK;
        state_d  = sts_i.fallback ? ST_WR_NODE : ST_NSQ2;
      end
      ST_NSQ2: begin
        cmd_o.op = DP_SQ;
        if (axis_q == 2'd2) begin
          axis_d  = '0;
          state_d = ST_NROOT_LD;
        end else begin
          axis_d = axis_q + 2'd1;
        end
      end
      ST_NROOT_LD: begin
        cmd_o.op = DP_NROOT_LD;
        step_d   = '0;
        state_d  = ST_NROOT;
      end
      ST_NROOT: begin
        cmd_o.op = DP_ROOT_STEP;
        step_d   = step_q + STEP_W'(1);
        if (step_q == STEP_W'(ROOT_STEPS - 1)) begin
          axis_d  = '0;
          state_d = ST_DIV_LD;
        end
      end
      ST_DIV_LD: begin
        cmd_o.op = DP_DIV_LD;
        step_d   = '0;
        state_d  = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.op = DP_DIV_STEP;
        step_d   = step_q + STEP_W'(1);
        if (step_q == STEP_W'(QUOT_W - 1)) begin
          state_d = ST_DIV_END;
        end
      end
      ST_DIV_END: begin
        cmd_o.op = DP_DIV_END;
        if (axis_q == 2'd2) begin
          axis_d  = '0;
          state_d = ST_WR_NODE;
        end else begin
          axis_d  = axis_q + 2'd1;
          state_d = ST_DIV_LD;
        end
      end
      ST_WR_NODE: begin
        cmd_o.op = DP_WR_NODE;
        state_d  = sts_i.is_root ? ST_DONE : ST_WR_PAR;
      end
      ST_WR_PAR: begin
        cmd_o.op = DP_WR_PAR;
        state_d  = ST_DONE;
      end
      ST_DONE: begin
        // Hand over only once the output register is free.
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.op    = DP_OUT;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign in_stall_o  = state_q != ST_IDLE;
  assign out_valid_o = out_valid_q;

  // An accepted transaction goes straight to the parent lookup.
  a_accept_lookup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q == ST_LOOKUP))
    else $error("accepted transaction did not start the lookup");

  // A rejected insertion skips all arithmetic.
  a_err_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_LOOKUP && sts_i.err != STS_OK) |=> (state_q == ST_DONE))
    else $error("rejected transaction did not go to completion");

  // A waiting result is never overwritten.
  a_done_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && out_valid_q && out_stall_i) |=> (state_q == ST_DONE))
    else $error("result handed over while the output register was full");

  // A new result appears only from the completion state.
  a_valid_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == ST_DONE))
    else $error("output valid rose outside the completion state");

endmodule

`default_nettype wire

FILE: rtl/tree_node_insert_arc_length_unit.sv
// Top level of the tree node insert unit with arc length and unit direction.
//
//   Channel  Direction  Handshake                Payload
//   in       input      in_valid_i / in_stall_o  in_data_i  (in_t)
//   out      output     out_valid_o / out_stall_i out_data_o (out_t)
//   cfg      input      cfg_we_i                 cfg_index_i, cfg_wdata_i
//
// A child insertion runs two 32-step bit-serial square roots (distance and
// direction length) and three 15-step restoring divisions; a root runs only
// the direction length root and the divisions. A direction below the limit
// skips the normalisation after its magnitude check, and a rejected transaction
// skips all arithmetic. One transaction is in work at a time and the input
// stalls until its result is handed to the output register, so no new one is
// taken before the last is through; a finished result waits there while the
// next transaction is accepted, and a stalled output holds the unit in its
// completion state. Reset empties the node table at once; no clearing pass is
// needed.
`default_nettype none

module tree_node_insert_arc_length_unit import tnia_pkg::*; #(
  parameter int unsigned MAX_NODES = MAX_NODES_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire in_t                  in_data_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output out_t                      out_data_o,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [CFG_W-1:0]     cfg_wdata_i
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  // Sequencer.
  tnia_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Arithmetic and node store.
  tnia_datapath #(.MAX_NODES(MAX_NODES)) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

FILE: tb/tb.sv
// Self-checking testbench for the tree node insert unit with arc length.
`default_nettype none

module tb;
  import tnia_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef longint vec3_t [3];

  // One row of the directed stimulus table.
  typedef struct {
    in_t  item;
    bit   typed;
    out_t result;
  } row_t;

  localparam int unsigned CYCLE_LIMIT = 2000000;
  localparam int unsigned DRAIN_WAIT  = 150;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned NODES       = MAX_NODES_DEF;
  localparam int unsigned CHAIN_LEN   = 160;

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_stall_o;
  in_t  in_data_i;
  logic out_valid_o;
  logic out_stall_i;
  out_t out_data_o;
  logic cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [CFG_W-1:0] cfg_wdata_i;

  tree_node_insert_arc_length_unit i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // Shadow copy of the node table and the registers.
  longint unsigned zero_limit;
  logic [FLAG_W-1:0] root_flag;
  int unsigned node_total;
  vec3_t node_pos   [NODES];
  vec3_t node_dir   [NODES];
  int unsigned node_depth [NODES];
  longint unsigned node_len [NODES];
  int unsigned node_kids  [NODES];

  out_t expected_nodes [$];
  bit   failed;
  int unsigned cycles;
  int unsigned send_idle;
  int unsigned recv_stall;
  bit   hold_req;

  // Clock.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Run limit.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  function automatic longint unsigned int_sqrt(input longint unsigned x);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // Unit direction in Q1.14, or the fallback when the raw vector is too short.
  function automatic void unit_dir(input vec3_t d, input vec3_t fb, output vec3_t u);
    longint unsigned a [3];
    longint unsigned s, mx, s2, m, q;
    int n;
    s = 0;
    mx = 0;
    s2 = 0;
    n = 0;
    for (int i = 0; i < 3; i++) begin
      a[i] = (d[i] < 0) ? longint'(-d[i]) : longint'(d[i]);
      s += a[i] * a[i];
      if (a[i] > mx) mx = a[i];
    end
    if (s == 0 || s < zero_limit) begin
      u = fb;
      return;
    end
    while (n < 64 && (mx >> n) != 0) n++;
    for (int i = 0; i < 3; i++) begin
      if (n > 16) a[i] >>= (n - 16);
      else a[i] <<= (16 - n);
      s2 += a[i] * a[i];
    end
    m = int_sqrt(s2 << 28);
    for (int i = 0; i < 3; i++) begin
      q = ((a[i] << 28) + (m >> 1)) / m;
      if (q > UNIT_ONE) q = UNIT_ONE;
      u[i] = (d[i] < 0) ? -longint'(q) : longint'(q);
    end
  endfunction

  // Works out the result of one insertion and updates the shadow table.
  function automatic out_t insert_node(input in_t x);
    out_t r;
    vec3_t p, d, u, up;
    int unsigned idx, dep, par;
    longint unsigned len, sum, span, df;
    r = '0;
    p[0] = x.pos_x;
    p[1] = x.pos_y;
    p[2] = x.pos_z;
    d[0] = x.dir_x;
    d[1] = x.dir_y;
    d[2] = x.dir_z;
    up[0] = 0;
    up[1] = 0;
    up[2] = UNIT_ONE;
    par = x.parent_index;
    if (x.op) begin
      idx = 0;
      dep = 0;
      len = 0;
      unit_dir(d, up, u);
      r.node_flags = root_flag;
    end else begin
      if (par >= node_total) begin
        r.status = STS_BAD_PARENT;
        return r;
      end
      if (node_total >= NODES) begin
        r.status = STS_FULL;
        return r;
      end
      idx = node_total;
      dep = (node_depth[par] < SAT10) ? node_depth[par] + 1 : SAT10;
      sum = 0;
      for (int i = 0; i < 3; i++) begin
        df = (p[i] > node_pos[par][i]) ? p[i] - node_pos[par][i] : node_pos[par][i] - p[i];
        sum += df * df;
      end
      span = int_sqrt(sum);
      if (sum - span * span > span) span++;
      len = node_len[par] + span;
      if (len > 64'hFFFF_FFFF) len = 64'hFFFF_FFFF;
      unit_dir(d, node_dir[par], u);
      if (node_kids[par] < SAT10) node_kids[par]++;
      r.parent_children = IDX_W'(node_kids[par]);
      r.node_flags = x.flags;
    end
    node_pos[idx] = p;
    node_dir[idx] = u;
    node_depth[idx] = dep;
    node_len[idx] = len;
    node_kids[idx] = 0;
    node_total = idx + 1;
    r.status = STS_OK;
    r.node_index = IDX_W'(idx);
    r.depth = IDX_W'(dep);
    r.along_len = LEN_W'(len);
    r.unit_x = UNIT_W'(u[0]);
    r.unit_y = UNIT_W'(u[1]);
    r.unit_z = UNIT_W'(u[2]);
    return r;
  endfunction

  function automatic in_t node_item(input bit op, input int par, input int px, input int py,
                                    input int pz, input int dx, input int dy, input int dz,
                                    input int fl);
    in_t x;
    x.op = op;
    x.parent_index = IDX_W'(par);
    x.pos_x = POS_W'(px);
    x.pos_y = POS_W'(py);
    x.pos_z = POS_W'(pz);
    x.dir_x = DIR_W'(dx);
    x.dir_y = DIR_W'(dy);
    x.dir_z = DIR_W'(dz);
    x.flags = FLAG_W'(fl);
    return x;
  endfunction

  function automatic out_t typed_result(input status_e st, input int unit_z, input int fl);
    out_t r;
    r = '0;
    r.status = st;
    r.unit_z = UNIT_W'(unit_z);
    r.node_flags = FLAG_W'(fl);
    return r;
  endfunction

  // Offers one transaction and records its expected result on acceptance.
  task automatic send_node(input in_t x, input bit typed, input out_t result);
    out_t pred;
    if ($urandom_range(99) < send_idle) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle);
    end
    in_valid_i <= 1'b1;
    in_data_i <= x;
    do @(posedge clk_i); while (in_stall_o);
    pred = insert_node(x);
    expected_nodes.push_back(typed ? result : pred);
  endtask

  // Waits until every result has come and the block has gone quiet.
  task automatic drain;
    in_valid_i <= 1'b0;
    while (expected_nodes.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  // Writes both registers; only called with the block idle.
  task automatic write_regs(input logic [31:0] limit, input logic [7:0] flag);
    cfg_we_i <= 1'b1;
    cfg_index_i <= CFG_DIR_ZERO_LIMIT;
    cfg_wdata_i <= limit;
    @(posedge clk_i);
    cfg_index_i <= CFG_ROOT_FLAG_VALUE;
    cfg_wdata_i <= {24'd0, flag};
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    zero_limit = limit;
    root_flag = flag;
  endtask

  function automatic int rand_pos();
    case ($urandom_range(3))
      0: return $urandom_range(2000) - 1000;
      1: return $urandom_range(1) ? 8388607 : -8388608;
      default: return int'($urandom) >>> 8;
    endcase
  endfunction

  function automatic int rand_dir();
    case ($urandom_range(3))
      0: return $urandom_range(6) - 3;
      1: return $urandom_range(1) ? 32767 : -32768;
      default: return int'($urandom) >>> 16;
    endcase
  endfunction

  // Random insertion: mostly valid children, some roots and bad parents.
  function automatic in_t rand_node();
    int unsigned pick;
    int par;
    pick = $urandom_range(99);
    if (pick < 8 || node_total == 0)
      return node_item(1'b1, $urandom_range(1023), rand_pos(), rand_pos(), rand_pos(),
                       rand_dir(), rand_dir(), rand_dir(), $urandom_range(255));
    if (pick < 14) par = $urandom_range(1023, node_total < 1024 ? node_total : 0);
    else if (pick < 50) par = node_total - 1;
    else par = $urandom_range(node_total - 1);
    return node_item(1'b0, par, rand_pos(), rand_pos(), rand_pos(), rand_dir(), rand_dir(),
                     rand_dir(), $urandom_range(255));
  endfunction

  // Receiver: random stall, an optional long hold-off, and the result check.
  int unsigned hold_left;
  always @(posedge clk_i) begin
    out_t want;
    if (hold_req && hold_left == 0) begin
      hold_left = HOLD_CYCLES;
      hold_req = 1'b0;
    end
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_nodes.size() == 0) begin
        $error("result with no transaction outstanding");
        failed = 1'b1;
      end else begin
        want = expected_nodes.pop_front();
        if (out_data_o.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_data_o.status);
          failed = 1'b1;
        end
        if (out_data_o.node_index !== want.node_index) begin
          $error("node_index: expected %0d, got %0d", want.node_index, out_data_o.node_index);
          failed = 1'b1;
        end
        if (out_data_o.depth !== want.depth) begin
          $error("depth: expected %0d, got %0d", want.depth, out_data_o.depth);
          failed = 1'b1;
        end
        if (out_data_o.along_len !== want.along_len) begin
          $error("along_len: expected %0h, got %0h", want.along_len, out_data_o.along_len);
          failed = 1'b1;
        end
        if (out_data_o.unit_x !== want.unit_x) begin
          $error("unit_x: expected %0d, got %0d", want.unit_x, out_data_o.unit_x);
          failed = 1'b1;
        end
        if (out_data_o.unit_y !== want.unit_y) begin
          $error("unit_y: expected %0d, got %0d", want.unit_y, out_data_o.unit_y);
          failed = 1'b1;
        end
        if (out_data_o.unit_z !== want.unit_z) begin
          $error("unit_z: expected %0d, got %0d", want.unit_z, out_data_o.unit_z);
          failed = 1'b1;
        end
        if (out_data_o.parent_children !== want.parent_children) begin
          $error("parent_children: expected %0d, got %0d", want.parent_children,
                 out_data_o.parent_children);
          failed = 1'b1;
        end
        if (out_data_o.node_flags !== want.node_flags) begin
          $error("node_flags: expected %0h, got %0h", want.node_flags, out_data_o.node_flags);
          failed = 1'b1;
        end
      end
    end
    if (hold_left != 0) begin
      hold_left = hold_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_stall);
    end
  end

  // Stimulus.
  initial begin
    row_t rows [$];
    in_t x;
    int unsigned modes_in [4];
    int unsigned modes_out [4];
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    out_stall_i = 1'b0;
    cfg_we_i = 1'b0;
    cfg_index_i = '0;
    cfg_wdata_i = '0;
    cycles = 0;
    failed = 1'b0;
    send_idle = 0;
    recv_stall = 0;
    hold_req = 1'b0;
    hold_left = 0;
    zero_limit = 1;
    root_flag = 1;
    node_total = 0;
    modes_in = '{0, 81, 0, 6};
    modes_out = '{0, 0, 81, 6};
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table with register values from reset.
    rows.push_back('{node_item(0, 0, 0, 0, 0, 5, 5, 5, 7), 1,
                     typed_result(STS_BAD_PARENT, 0, 0)});
    rows.push_back('{node_item(1, 1023, 0, 0, 0, 0, 0, 0, 255), 1,
                     typed_result(STS_OK, UNIT_ONE, 1)});
    rows.push_back('{node_item(1, 0, 8388607, 8388607, 8388607, -32768, -32768, -32768, 0),
                     0, '0});
    rows.push_back('{node_item(0, 0, -8388608, -8388608, -8388608, 32767, 32767, 32767, 255),
                     0, '0});
    rows.push_back('{node_item(0, 1, 100, -200, 300, 0, 0, 0, 3), 0, '0});
    rows.push_back('{node_item(0, 1023, 0, 0, 0, 1, 1, 1, 1), 1,
                     typed_result(STS_BAD_PARENT, 0, 0)});
    rows.push_back('{node_item(0, 3, 0, 0, 0, 1, 1, 1, 1), 1,
                     typed_result(STS_BAD_PARENT, 0, 0)});
    rows.push_back('{node_item(0, 2, 0, 0, 0, 1, 0, 0, 8'h80), 0, '0});
    rows.push_back('{node_item(0, 0, 1, 1, 1, 0, -1, 0, 8'h01), 0, '0});
    rows.push_back('{node_item(0, 3, 24'h555555, 24'hAAAAAA, 24'h555555, 16'hAAAA, 16'h5555,
                               16'hAAAA, 8'h00), 0, '0});
    rows.push_back('{node_item(0, 4, -1, -1, -1, 32767, -32768, 1, 8'h5A), 0, '0});
    foreach (rows[i]) send_node(rows[i].item, rows[i].typed, rows[i].result);
    drain();

    // Every raw direction falls back; root flag at its low extreme.
    write_regs(32'hFFFF_FFFF, 8'h00);
    rows.delete();
    rows.push_back('{node_item(1, 0, 0, 0, 0, 100, 0, 0, 9), 1,
                     typed_result(STS_OK, UNIT_ONE, 0)});
    rows.push_back('{node_item(0, 0, 5, 5, 5, 32767, 32767, 32767, 2), 0, '0});
    foreach (rows[i]) send_node(rows[i].item, rows[i].typed, rows[i].result);
    drain();

    // No threshold; root flag at its high extreme.
    write_regs(32'd0, 8'hFF);
    rows.delete();
    rows.push_back('{node_item(1, 0, 0, 0, 0, 0, 0, 0, 9), 1,
                     typed_result(STS_OK, UNIT_ONE, 255)});
    rows.push_back('{node_item(0, 0, 7, -7, 7, -32768, 0, 0, 4), 0, '0});
    rows.push_back('{node_item(0, 1, 7, -7, 7, 0, 0, 0, 4), 0, '0});
    foreach (rows[i]) send_node(rows[i].item, rows[i].typed, rows[i].result);
    drain();

    // A zig-zag chain between opposite corners saturates the arc length.
    write_regs(32'd1, 8'h01);
    send_node(node_item(1, 0, 8388607, 8388607, 8388607, 1, 2, 3, 0), 0, '0);
    for (int k = 1; k < CHAIN_LEN; k++) begin
      x = rand_node();
      x.op = 1'b0;
      x.parent_index = IDX_W'(node_total - 1);
      x.pos_x = node_total[0] ? -24'sd8388608 : 24'sd8388607;
      x.pos_y = x.pos_x;
      x.pos_z = x.pos_x;
      send_node(x, 0, '0);
    end
    drain();

    // Random part over the idling phases; the first one holds the receiver off.
    for (int ph = 0; ph < 4; ph++) begin
      write_regs(($urandom_range(3) == 0) ? $urandom : $urandom_range(4096),
                 FLAG_W'($urandom_range(255)));
      send_idle = modes_in[ph];
      recv_stall = modes_out[ph];
      if (ph == 0) hold_req = 1'b1;
      if (node_total == NODES) send_node(rand_node(), 0, '0);
      for (int n = 0; n < 95; n++) send_node(rand_node(), 0, '0);
      drain();
    end

    if (failed || expected_nodes.size() != 0) begin
      $display("tb: FAIL");
    end else begin
      $display("tb: PASS");
    end
    $finish;
  end

endmodule

`default_nettype wire
